// ----- rtl/core/sha256_byte_stream_hasher_unit_defines.svh -----
// Assertion macros shared by the SHA-256 byte stream hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/shb_pkg.sv -----
// Shared types, constants and SHA-256 functions for the byte stream hasher.
package shb_pkg;

	// Working variables a..h of one compression, index 0 is a.
	typedef logic [7:0][31:0] shb_work_t;
	// Sixteen-word message schedule window, index 15 holds the current word.
	typedef logic [15:0][31:0] shb_sched_t;

	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] LEN_POS     = 6'd56;
	localparam logic [5:0] LAST_BYTE   = 6'd63;
	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [2:0] LAST_WORD   = 3'd7;

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			3'd7: h = 32'h5be0cd19;
			default: h = 32'h0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ----- rtl/core/shb_round.sv -----
// One SHA-256 compression round and the matching message schedule step.
module shb_round import shb_pkg::*; (
	input  shb_work_t   work,
	input  logic [5:0]  round_idx,
	input  logic [31:0] w_t,
	input  logic [31:0] w_t1,
	input  logic [31:0] w_t9,
	input  logic [31:0] w_t14,
	output shb_work_t   work_nxt,
	output logic [31:0] w_new
);

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
		maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
		t1  = work[7] + big_sigma1(work[4]) + ch + round_k(round_idx) + w_t;
		t2  = big_sigma0(work[0]) + maj;
		work_nxt[0] = t1 + t2;
		work_nxt[1] = work[0];
		work_nxt[2] = work[1];
		work_nxt[3] = work[2];
		work_nxt[4] = work[3] + t1;
		work_nxt[5] = work[4];
		work_nxt[6] = work[5];
		work_nxt[7] = work[6];
	end

	// Word sixteen places ahead of the current one in the schedule.
	assign w_new = w_t + small_sigma0(w_t1) + w_t9 + small_sigma1(w_t14);

endmodule

// ----- rtl/core/sha256_byte_stream_hasher_unit.sv -----
// Top level of the SHA-256 byte stream hasher with its chaining word memory.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid, in_stall | data_byte, byte_present, end_of_message
//   output  | out_valid, out_stall | digest_word, word_index, last_word
//
// A byte that neither completes a block nor ends the message leaves in_stall low.
// A full block holds the input while the working words load from the chaining memory,
// 64 rounds run at one per cycle and the results are added back and written to it.
// End of message pads one byte per cycle, runs one or two compressions and then
// reads out each digest word in S_ORD and S_OLD through the single memory read port.
// Reset needs no clearing pass: unwritten chaining words read as the initial values.
// A stalled output word holds the readout; input is taken again once word 7 is loaded.
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_byte_stream_hasher_unit import shb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0; // waiting for input transfers
	localparam logic [2:0] S_PAD   = 3'd1; // shifting in padding and length bytes
	localparam logic [2:0] S_LOAD  = 3'd2; // reading chaining words into a..h
	localparam logic [2:0] S_ROUND = 3'd3; // 64 compression rounds
	localparam logic [2:0] S_WB    = 3'd4; // adding a..h back into the memory
	localparam logic [2:0] S_ORD   = 3'd5; // reading one digest word
	localparam logic [2:0] S_OLD   = 3'd6; // loading it into the output register

	logic [2:0]  state_q;
	logic [5:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic        mark_q;   // the 0x80 byte still has to go in
	logic        tail_q;   // the length may go into the last eight bytes of this block
	logic        pad_q;    // padding continues after the running compression
	logic        final_q;  // the running compression is the last of the message

	shb_sched_t  w_q;
	shb_work_t   v_q;
	shb_work_t   v_nxt;
	logic [31:0] w_new;

	// Chaining word memory with a valid bit for each entry.
	logic [31:0] chain_mem [8];
	logic [7:0]  chain_vld_q;
	logic        rd_en;
	logic [2:0]  rd_addr;
	logic        rd_en_s1;
	logic [2:0]  rd_addr_s1;
	logic        rd_vld_s1;
	logic [31:0] rd_mem_s1;
	logic [31:0] rd_data;
	logic        wr_en;
	logic [31:0] wr_data;

	logic        in_xfer;
	logic        out_free;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic [7:0]  pad_byte;
	logic [63:0] len_bits;

	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_index_q;
	logic        out_last_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Padding byte: the marker first, then zeros, then the bit length big-endian.
	assign len_bits = {len_q, 3'b000};
	always_comb begin
		if (mark_q) begin
			pad_byte = PAD_MARK;
		end else if (tail_q && fill_q >= LEN_POS) begin
			pad_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign shift_en   = (in_xfer && byte_present) || (state_q == S_PAD);
	assign shift_byte = (state_q == S_PAD) ? pad_byte : data_byte;

	// Memory port control. Reads in write-back run one entry ahead of the writes.
	assign rd_en = (((state_q == S_LOAD) || (state_q == S_WB)) && !cnt_q[3])
		|| ((state_q == S_ORD) && out_free);
	assign rd_addr = cnt_q[2:0];
	assign rd_data = rd_vld_s1 ? rd_mem_s1 : init_h(rd_addr_s1);
	assign wr_en   = (state_q == S_WB) && rd_en_s1;
	assign wr_data = rd_data + v_q[0];

	shb_round u_round (
		.work      (v_q),
		.round_idx (cnt_q),
		.w_t       (w_q[15]),
		.w_t1      (w_q[14]),
		.w_t9      (w_q[6]),
		.w_t14     (w_q[1]),
		.work_nxt  (v_nxt),
		.w_new     (w_new)
	);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mem_s1 <= chain_mem[rd_addr];
		end
		if (wr_en) begin
			chain_mem[rd_addr_s1] <= wr_data;
		end
		rd_addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			chain_vld_q <= '0;
		end else begin
			rd_en_s1  <= rd_en;
			rd_vld_s1 <= chain_vld_q[rd_addr];
			if (wr_en) begin
				chain_vld_q[rd_addr_s1] <= 1'b1;
			end
			if (state_q == S_OLD && cnt_q[2:0] == LAST_WORD) begin
				chain_vld_q <= '0;
			end
		end
	end

	// Message bytes and padding shift into the schedule window; rounds shift words.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			w_q <= {w_q[15][23:0], w_q[14:0], shift_byte};
		end else if (state_q == S_ROUND) begin
			w_q <= {w_q[14:0], w_new};
		end
	end

	// Working words: filled from the memory, updated by rounds, rotated in write-back.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && rd_en_s1) begin
			v_q <= {rd_data, v_q[7:1]};
		end else if (state_q == S_ROUND) begin
			v_q <= v_nxt;
		end else if (state_q == S_WB && rd_en_s1) begin
			v_q <= {v_q[0], v_q[7:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			len_q       <= '0;
			mark_q      <= 1'b0;
			tail_q      <= 1'b0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (byte_present) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 61'd1;
						end
						if (byte_present && fill_q == LAST_BYTE) begin
							state_q <= S_LOAD;
							cnt_q   <= '0;
							pad_q   <= end_of_message;
							mark_q  <= end_of_message;
							tail_q  <= 1'b0;
							final_q <= 1'b0;
						end else if (end_of_message) begin
							state_q <= S_PAD;
							mark_q  <= 1'b1;
							tail_q  <= 1'b0;
						end
					end
				end
				S_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (mark_q) begin
						mark_q <= 1'b0;
						if (fill_q < LEN_POS) begin
							tail_q <= 1'b1;
						end
					end
					if (fill_q == LAST_BYTE) begin
						state_q <= S_LOAD;
						cnt_q   <= '0;
						final_q <= tail_q && !mark_q;
						pad_q   <= !(tail_q && !mark_q);
					end
				end
				S_LOAD: begin
					if (cnt_q[3]) begin
						state_q <= S_ROUND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == LAST_ROUND) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (cnt_q[3]) begin
						cnt_q <= '0;
						if (final_q) begin
							state_q <= S_ORD;
							final_q <= 1'b0;
						end else if (pad_q) begin
							state_q <= S_PAD;
							tail_q  <= 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_ORD: begin
					if (rd_en) begin
						state_q <= S_OLD;
					end
				end
				S_OLD: begin
					out_valid_q <= 1'b1;
					if (cnt_q[2:0] == LAST_WORD) begin
						state_q <= S_IDLE;
						cnt_q   <= '0;
						fill_q  <= '0;
						len_q   <= '0;
					end else begin
						state_q <= S_ORD;
						cnt_q   <= cnt_q + 6'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OLD) begin
			out_word_q  <= rd_data;
			out_index_q <= cnt_q[2:0];
			out_last_q  <= (cnt_q[2:0] == LAST_WORD);
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = out_word_q;
	assign word_index  = out_index_q;
	assign last_word   = out_last_q;

	`SHB_ASSERT_NOW(a_wr_in_wb, wr_en, state_q == S_WB, "chain memory written outside write-back")
	`SHB_ASSERT_NOW(a_digest_aligned, state_q == S_ORD, fill_q == 6'd0 && !mark_q && !pad_q, "digest readout with padding unfinished")
	`SHB_ASSERT_NEXT(a_reinit, state_q == S_OLD && cnt_q[2:0] == LAST_WORD, state_q == S_IDLE && len_q == 61'd0 && chain_vld_q == 8'd0, "message state not reinitialized after digest")
	`SHB_ASSERT_NEXT(a_out_hold, state_q == S_ORD && out_valid_q && out_stall, state_q == S_ORD, "digest readout advanced over a stalled word")

endmodule
